/* design/fcalu_pkg.sv */
`default_nettype none

package fcalu_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NLANE       = 4;
    localparam int LANE_BITS   = 2;
    localparam int OP_BITS     = 4;

    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int SUM_BITS    = PROD_BITS + LANE_BITS;
    localparam int WIDE_BITS   = SUM_BITS - FRAC_BITS;
    localparam int SIMPLE_BITS = WORD_BITS + 3;

    localparam logic [OP_BITS-1:0] OP_ADD      = OP_BITS'(0);
    localparam logic [OP_BITS-1:0] OP_ADD_COMP = OP_BITS'(1);
    localparam logic [OP_BITS-1:0] OP_MUL      = OP_BITS'(2);
    localparam logic [OP_BITS-1:0] OP_SCALE    = OP_BITS'(3);
    localparam logic [OP_BITS-1:0] OP_CONJ1    = OP_BITS'(4);
    localparam logic [OP_BITS-1:0] OP_CONJ2    = OP_BITS'(5);
    localparam logic [OP_BITS-1:0] OP_CONJ3    = OP_BITS'(6);
    localparam logic [OP_BITS-1:0] OP_OPP      = OP_BITS'(7);
    localparam logic [OP_BITS-1:0] OP_COMP     = OP_BITS'(8);
    localparam logic [OP_BITS-1:0] OP_NORM     = OP_BITS'(9);
    localparam logic [OP_BITS-1:0] OP_CHECK    = OP_BITS'(10);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic [WORD_BITS-2:0]        norm_t;
    typedef word_t                       quad_t [NLANE];
    typedef prod_t                       prod_quad_t [NLANE];

    typedef struct packed {
        logic signed [WORD_BITS-1:0] value;
        logic                        ovf;
    } sat_t;

    // Clamp a wide signed value to the word range.
    function automatic sat_t saturate(input logic signed [WIDE_BITS-1:0] v);
        sat_t                            res;
        logic [WIDE_BITS-WORD_BITS:0]    hi_bits;
        hi_bits = v[WIDE_BITS-1:WORD_BITS-1];
        res.ovf = !((&hi_bits) || !(|hi_bits));
        if (!res.ovf)
            res.value = v[WORD_BITS-1:0];
        else if (v[WIDE_BITS-1])
            res.value = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            res.value = {1'b0, {(WORD_BITS-1){1'b1}}};
        return res;
    endfunction

    // Component of Y that multiplies X component j in result lane k (cyclic product).
    function automatic logic [LANE_BITS-1:0] y_index(input int k, input int j);
        return LANE_BITS'(k + NLANE - 1 - j);
    endfunction

endpackage

`default_nettype wire

/* design/fcalu_cmd_if.sv */
`default_nettype none

interface fcalu_cmd_if;
    import fcalu_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_BITS-1:0] opcode;
    word_t              x_a;
    word_t              x_b;
    word_t              x_c;
    word_t              x_e;
    word_t              y_a;
    word_t              y_b;
    word_t              y_c;
    word_t              y_e;
    word_t              scalar;

    modport source (
        output valid, opcode, x_a, x_b, x_c, x_e, y_a, y_b, y_c, y_e, scalar,
        input  ready
    );

    modport sink (
        input  valid, opcode, x_a, x_b, x_c, x_e, y_a, y_b, y_c, y_e, scalar,
        output ready
    );
endinterface

`default_nettype wire

/* design/fcalu_rsp_if.sv */
`default_nettype none

interface fcalu_rsp_if;
    import fcalu_pkg::*;

    logic  valid;
    logic  ready;
    word_t r_a;
    word_t r_b;
    word_t r_c;
    word_t r_e;
    norm_t norm_value;
    logic  overflow;
    logic  negative_found;

    modport source (
        output valid, r_a, r_b, r_c, r_e, norm_value, overflow, negative_found,
        input  ready
    );

    modport sink (
        input  valid, r_a, r_b, r_c, r_e, norm_value, overflow, negative_found,
        output ready
    );
endinterface

`default_nettype wire

/* design/fcalu_lane.sv */
`default_nettype none

module fcalu_lane (
    input  logic                  clk,
    input  logic                  en,
    input  fcalu_pkg::quad_t      a,
    input  fcalu_pkg::quad_t      b,
    output fcalu_pkg::prod_quad_t prod,
    output fcalu_pkg::word_t      r,
    output logic                  ovf
);
    import fcalu_pkg::*;

    localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
        (FRAC_BITS == 0) ? '0 : (SUM_BITS'(1) << (FRAC_BITS - 1));

    prod_quad_t                 prod_reg;
    logic signed [PROD_BITS:0]  pair_lo_reg;
    logic signed [PROD_BITS:0]  pair_hi_reg;
    logic signed [SUM_BITS-1:0] sum_reg;
    word_t                      r_reg;
    logic                       ovf_reg;
    sat_t                       sat_next;

    assign sat_next = saturate(WIDE_BITS'(sum_reg >>> FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NLANE; j++)
            begin
                prod_reg[j] <= a[j] * b[j];
            end
            pair_lo_reg <= (PROD_BITS+1)'(prod_reg[0]) + (PROD_BITS+1)'(prod_reg[1]);
            pair_hi_reg <= (PROD_BITS+1)'(prod_reg[2]) + (PROD_BITS+1)'(prod_reg[3]);
            // Round to nearest, ties up, ahead of the shift.
            sum_reg     <= SUM_BITS'(pair_lo_reg) + SUM_BITS'(pair_hi_reg) + ROUND_HALF;
            r_reg       <= sat_next.value;
            ovf_reg     <= sat_next.ovf;
        end
    end

    assign prod = prod_reg;
    assign r    = r_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

/* design/fcalu_norm.sv */
`default_nettype none

module fcalu_norm (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  active,
    input  fcalu_pkg::prod_quad_t sq,
    output fcalu_pkg::norm_t      norm,
    output logic                  ovf
);
    import fcalu_pkg::*;

    // Any square at or above 2^SQ_KEEP forces saturation, so only the low
    // SQ_KEEP bits are squared, split into two halves.
    localparam int NORM_SHIFT = 3 * FRAC_BITS;
    localparam int SQ_KEEP    = (NORM_SHIFT + WORD_BITS + 1) / 2;
    localparam int SQ_LO      = SQ_KEEP / 2;
    localparam int SQ_HI      = SQ_KEEP - SQ_LO;
    localparam int HH_BITS    = 2 * SQ_HI;
    localparam int HL_BITS    = SQ_KEEP;
    localparam int LL_BITS    = 2 * SQ_LO;
    localparam int TOT_BITS   = 2 * SQ_KEEP + 3;
    localparam int Q_BITS     = TOT_BITS - NORM_SHIFT;
    localparam logic [TOT_BITS-1:0] NORM_ROUND =
        (NORM_SHIFT == 0) ? '0 : (TOT_BITS'(1) << (NORM_SHIFT - 1));

    logic [SQ_HI-1:0]               sq_h [NLANE];
    logic [SQ_LO-1:0]               sq_l [NLANE];
    logic [NLANE-1:0]               big_next;

    logic [HH_BITS-1:0]             hh_reg [NLANE];
    logic [HL_BITS-1:0]             hl_reg [NLANE];
    logic [LL_BITS-1:0]             ll_reg [NLANE];
    logic [NLANE-1:0]               big2_reg;
    logic                           act2_reg;

    logic [HH_BITS+LANE_BITS-1:0]   hh_sum_next;
    logic [HL_BITS+LANE_BITS-1:0]   hl_sum_next;
    logic [LL_BITS+LANE_BITS-1:0]   ll_sum_next;
    logic [HH_BITS+LANE_BITS-1:0]   hh_sum_reg;
    logic [HL_BITS+LANE_BITS-1:0]   hl_sum_reg;
    logic [LL_BITS+LANE_BITS-1:0]   ll_sum_reg;
    logic                           big3_reg;
    logic                           act3_reg;

    logic [TOT_BITS-1:0]            tot_reg;
    logic                           big4_reg;
    logic                           act4_reg;

    logic [Q_BITS-1:0]              q;
    logic                           over;
    norm_t                          norm_reg;
    logic                           ovf_reg;

    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            big_next[k] = |sq[k][PROD_BITS-1:SQ_KEEP];
            sq_h[k]     = sq[k][SQ_KEEP-1:SQ_LO];
            sq_l[k]     = sq[k][SQ_LO-1:0];
        end
    end

    always_comb
    begin
        hh_sum_next = '0;
        hl_sum_next = '0;
        ll_sum_next = '0;
        for (int k = 0; k < NLANE; k++)
        begin
            hh_sum_next = hh_sum_next + (HH_BITS+LANE_BITS)'(hh_reg[k]);
            hl_sum_next = hl_sum_next + (HL_BITS+LANE_BITS)'(hl_reg[k]);
            ll_sum_next = ll_sum_next + (LL_BITS+LANE_BITS)'(ll_reg[k]);
        end
    end

    assign q    = tot_reg[TOT_BITS-1:NORM_SHIFT];
    assign over = big4_reg || (|q[Q_BITS-1:WORD_BITS-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                hh_reg[k] <= sq_h[k] * sq_h[k];
                hl_reg[k] <= sq_h[k] * sq_l[k];
                ll_reg[k] <= sq_l[k] * sq_l[k];
            end
            big2_reg   <= big_next;
            act2_reg   <= active;

            hh_sum_reg <= hh_sum_next;
            hl_sum_reg <= hl_sum_next;
            ll_sum_reg <= ll_sum_next;
            big3_reg   <= |big2_reg;
            act3_reg   <= act2_reg;

            // sq^2 = hh << 2*LO + 2*hl << LO + ll
            tot_reg    <= (TOT_BITS'(hh_sum_reg) << (2 * SQ_LO))
                        + (TOT_BITS'(hl_sum_reg) << (SQ_LO + 1))
                        + TOT_BITS'(ll_sum_reg) + NORM_ROUND;
            big4_reg   <= big3_reg;
            act4_reg   <= act3_reg;

            if (!act4_reg)
                norm_reg <= '0;
            else if (over)
                norm_reg <= '1;
            else
                norm_reg <= q[WORD_BITS-2:0];
            ovf_reg    <= act4_reg && over;
        end
    end

    assign norm = norm_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

/* design/four_component_algebra_alu.sv */
// Channel  Side    Handshake    Payload
// cmd      sink    valid/ready  opcode, x_a..x_e, y_a..y_e, scalar
// rsp      source  valid/ready  r_a..r_e, norm_value, overflow, negative_found
//
// One item enters per cycle while no result is held on rsp.
// The depth is set by the fourth-power path: square, split square, partial sums,
// final add with rounding, clamp.
// Reset clears the stage valid bits only.
// A result held on rsp freezes every stage and drops cmd.ready until it is taken.
`default_nettype none

module four_component_algebra_alu (
    input  logic        clk,
    input  logic        rst_n,
    fcalu_cmd_if.sink   cmd,
    fcalu_rsp_if.source rsp
);
    import fcalu_pkg::*;

    localparam int PIPE_DEPTH = 5;

    logic                        en;
    logic [PIPE_DEPTH-1:0]       valid_reg;

    quad_t                       x_in;
    quad_t                       y_in;
    quad_t                       lane_b [NLANE];
    prod_quad_t                  lane_prod [NLANE];
    word_t                       lane_r [NLANE];
    logic [NLANE-1:0]            lane_ovf;
    prod_quad_t                  norm_sq;
    norm_t                       norm_value;
    logic                        norm_ovf;

    logic [OP_BITS-1:0]          op1_reg;
    logic [OP_BITS-1:0]          op2_reg;
    logic [OP_BITS-1:0]          op3_reg;
    logic [OP_BITS-1:0]          op4_reg;
    logic                        norm_act1_reg;
    logic                        neg1_next;
    logic                        neg1_reg;
    logic                        neg2_reg;
    logic                        neg3_reg;
    logic                        neg4_reg;

    logic signed [WORD_BITS:0]   t1_next [NLANE];
    logic signed [WORD_BITS:0]   t1_reg [NLANE];
    logic signed [WORD_BITS:0]   lo01;
    logic signed [WORD_BITS:0]   lo23;
    logic signed [WORD_BITS:0]   hi01;
    logic signed [WORD_BITS:0]   hi23;
    logic signed [WORD_BITS:0]   bound2_next;
    logic signed [WORD_BITS:0]   bound2_reg;
    logic signed [WORD_BITS+1:0] t2_next [NLANE];
    logic signed [WORD_BITS+1:0] t2_reg [NLANE];
    logic signed [SIMPLE_BITS-1:0] d3_next [NLANE];
    logic signed [SIMPLE_BITS-1:0] d3_reg [NLANE];
    sat_t                        s4_sat [NLANE];
    logic                        s4_ovf_next;
    word_t                       s4_reg [NLANE];
    logic                        s4_ovf_reg;

    word_t                       r5_next [NLANE];
    logic                        ovf5_next;
    word_t                       r5_reg [NLANE];
    logic                        ovf5_reg;
    logic                        neg5_reg;

    assign en        = !rsp.valid || rsp.ready;
    assign cmd.ready = en;
    assign rsp.valid = valid_reg[PIPE_DEPTH-1];

    assign x_in[0] = cmd.x_a;
    assign x_in[1] = cmd.x_b;
    assign x_in[2] = cmd.x_c;
    assign x_in[3] = cmd.x_e;
    assign y_in[0] = cmd.y_a;
    assign y_in[1] = cmd.y_b;
    assign y_in[2] = cmd.y_c;
    assign y_in[3] = cmd.y_e;

    // Stage 1: multiplier operands and first sums
    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            for (int j = 0; j < NLANE; j++)
            begin
                unique case (cmd.opcode)
                    OP_MUL:   lane_b[k][j] = y_in[y_index(k, j)];
                    OP_SCALE: lane_b[k][j] = (j == k) ? cmd.scalar : '0;
                    OP_NORM:  lane_b[k][j] = (j == k) ? x_in[j] : '0;
                    default:  lane_b[k][j] = '0;
                endcase
            end
            unique case (cmd.opcode)
                OP_ADD, OP_ADD_COMP:
                    t1_next[k] = (WORD_BITS+1)'(x_in[k]) + (WORD_BITS+1)'(y_in[k]);
                default:
                    t1_next[k] = (WORD_BITS+1)'(x_in[k]);
            endcase
        end
        neg1_next = (cmd.opcode == OP_CHECK)
                 && (cmd.x_a[WORD_BITS-1] || cmd.x_b[WORD_BITS-1]
                  || cmd.x_c[WORD_BITS-1] || cmd.x_e[WORD_BITS-1]);
    end

    for (genvar g = 0; g < NLANE; g++)
    begin : g_lane
        fcalu_lane u_lane (
            .clk  (clk),
            .en   (en),
            .a    (x_in),
            .b    (lane_b[g]),
            .prod (lane_prod[g]),
            .r    (lane_r[g]),
            .ovf  (lane_ovf[g])
        );
    end

    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            norm_sq[k] = lane_prod[k][k];
        end
    end

    fcalu_norm u_norm (
        .clk    (clk),
        .en     (en),
        .active (norm_act1_reg),
        .sq     (norm_sq),
        .norm   (norm_value),
        .ovf    (norm_ovf)
    );

    // Stage 2: min/max, permutes, pair sums for conj3
    always_comb
    begin
        lo01 = (t1_reg[0] < t1_reg[1]) ? t1_reg[0] : t1_reg[1];
        lo23 = (t1_reg[2] < t1_reg[3]) ? t1_reg[2] : t1_reg[3];
        hi01 = (t1_reg[0] > t1_reg[1]) ? t1_reg[0] : t1_reg[1];
        hi23 = (t1_reg[2] > t1_reg[3]) ? t1_reg[2] : t1_reg[3];
        unique case (op1_reg)
            OP_ADD_COMP, OP_COMP: bound2_next = (lo01 < lo23) ? lo01 : lo23;
            OP_OPP:               bound2_next = (hi01 > hi23) ? hi01 : hi23;
            default:              bound2_next = '0;
        endcase
        unique case (op1_reg)
            OP_CONJ1:
            begin
                t2_next[0] = (WORD_BITS+2)'(t1_reg[1]);
                t2_next[1] = (WORD_BITS+2)'(t1_reg[2]);
                t2_next[2] = (WORD_BITS+2)'(t1_reg[0]);
                t2_next[3] = (WORD_BITS+2)'(t1_reg[3]);
            end
            OP_CONJ2:
            begin
                t2_next[0] = (WORD_BITS+2)'(t1_reg[2]);
                t2_next[1] = (WORD_BITS+2)'(t1_reg[0]);
                t2_next[2] = (WORD_BITS+2)'(t1_reg[1]);
                t2_next[3] = (WORD_BITS+2)'(t1_reg[3]);
            end
            OP_CONJ3:
            begin
                t2_next[0] = (WORD_BITS+2)'(t1_reg[0]) + (WORD_BITS+2)'(t1_reg[1]);
                t2_next[1] = (WORD_BITS+2)'(t1_reg[2]) + (WORD_BITS+2)'(t1_reg[3]);
                t2_next[2] = '0;
                t2_next[3] = '0;
            end
            default:
            begin
                for (int k = 0; k < NLANE; k++)
                begin
                    t2_next[k] = (WORD_BITS+2)'(t1_reg[k]);
                end
            end
        endcase
    end

    // Stage 3: offset against the bound, or the full conj3 sum
    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            unique case (op2_reg)
                OP_OPP:
                    d3_next[k] = SIMPLE_BITS'(bound2_reg) - SIMPLE_BITS'(t2_reg[k]);
                OP_CONJ3:
                    d3_next[k] = (k == NLANE - 1)
                               ? SIMPLE_BITS'(t2_reg[0]) + SIMPLE_BITS'(t2_reg[1]) : '0;
                default:
                    d3_next[k] = SIMPLE_BITS'(t2_reg[k]) - SIMPLE_BITS'(bound2_reg);
            endcase
        end
    end

    // Stage 4: clamp
    always_comb
    begin
        s4_ovf_next = 1'b0;
        for (int k = 0; k < NLANE; k++)
        begin
            s4_sat[k]   = saturate(WIDE_BITS'(d3_reg[k]));
            s4_ovf_next = s4_ovf_next || s4_sat[k].ovf;
        end
    end

    // Stage 5: pick the path that owns this opcode
    always_comb
    begin
        unique case (op4_reg)
            OP_MUL, OP_SCALE:
            begin
                r5_next   = lane_r;
                ovf5_next = |lane_ovf;
            end
            OP_ADD, OP_ADD_COMP, OP_COMP, OP_OPP, OP_CONJ1, OP_CONJ2, OP_CONJ3:
            begin
                for (int k = 0; k < NLANE; k++)
                begin
                    r5_next[k] = s4_reg[k];
                end
                ovf5_next = s4_ovf_reg;
            end
            default:
            begin
                for (int k = 0; k < NLANE; k++)
                begin
                    r5_next[k] = '0;
                end
                ovf5_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], cmd.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg       <= cmd.opcode;
            op2_reg       <= op1_reg;
            op3_reg       <= op2_reg;
            op4_reg       <= op3_reg;
            norm_act1_reg <= (cmd.opcode == OP_NORM);
            neg1_reg      <= neg1_next;
            neg2_reg      <= neg1_reg;
            neg3_reg      <= neg2_reg;
            neg4_reg      <= neg3_reg;
            neg5_reg      <= neg4_reg;
            t1_reg        <= t1_next;
            bound2_reg    <= bound2_next;
            t2_reg        <= t2_next;
            d3_reg        <= d3_next;
            for (int k = 0; k < NLANE; k++)
            begin
                s4_reg[k] <= s4_sat[k].value;
            end
            s4_ovf_reg    <= s4_ovf_next;
            r5_reg        <= r5_next;
            ovf5_reg      <= ovf5_next;
        end
    end

    assign rsp.r_a            = r5_reg[0];
    assign rsp.r_b            = r5_reg[1];
    assign rsp.r_c            = r5_reg[2];
    assign rsp.r_e            = r5_reg[3];
    assign rsp.norm_value     = norm_value;
    assign rsp.overflow       = ovf5_reg || norm_ovf;
    assign rsp.negative_found = neg5_reg;

    // A check result carries nothing but the flag.
    a_check_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.negative_found |->
            rsp.r_a == '0 && rsp.r_b == '0 && rsp.r_c == '0 && rsp.r_e == '0
            && rsp.norm_value == '0 && !rsp.overflow)
        else $error("check result carries nonzero fields");

    a_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.norm_value != '0 |->
            rsp.r_a == '0 && rsp.r_b == '0 && rsp.r_c == '0 && rsp.r_e == '0
            && !rsp.negative_found)
        else $error("norm result carries component fields");

    a_norm_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && norm_ovf |-> rsp.norm_value == '1 && !ovf5_reg)
        else $error("norm overflow without clamped value");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(valid_reg))
        else $error("stage valid bits moved during stall");

endmodule

`default_nettype wire
